FILE: design/ifmt_pkg.sv
// shared types, constants and helpers for the integer to ascii formatter
`timescale 1ns / 1ps

package ifmt_pkg;

  localparam int VALUE_BITS = 64;
  localparam int VAL_W      = 64;
  localparam int OP_W       = 2;
  localparam int ROOM_W     = 8;
  localparam int CHAR_W     = 8;

  // decimal digits needed for VALUE_BITS bits: floor(bits * log10(2)) + 1
  localparam int NDIG   = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int DIG_W  = 4 * NDIG;
  localparam int CNT_W  = $clog2(VALUE_BITS);
  localparam int SKIP_W = $clog2(NDIG);
  localparam int LEFT_W = $clog2(NDIG + 1);

  localparam logic [OP_W-1:0] OP_SDEC = 2'd0;
  localparam logic [OP_W-1:0] OP_UDEC = 2'd1;
  localparam logic [OP_W-1:0] OP_HEX  = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [OP_W-1:0]   op;
    logic              wide;
    logic [ROOM_W-1:0] room;
  } ifmt_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } ifmt_out_t;

  // control word from the sequencer to the digit register
  typedef struct packed {
    logic load;
    logic dabble;
    logic shift;
    logic bit_in;
  } ifmt_bcd_ctl_t;

  function automatic logic [CHAR_W-1:0] nib_to_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] ext;
    ext = {4'd0, nib};
    if (nib < 4'd10) begin
      return CH_ZERO + ext;
    end else begin
      return CH_A + (ext - 8'd10);
    end
  endfunction

endpackage

FILE: design/ifmt_bcd.sv
// digit register: serial double-dabble conversion and nibble shift-out
`timescale 1ns / 1ps

module ifmt_bcd (
  input  logic                          clk_i,
  input  ifmt_pkg::ifmt_bcd_ctl_t       ctl_i,
  input  logic [ifmt_pkg::VALUE_BITS-1:0] load_val_i,
  output logic [3:0]                    top_o
);
  import ifmt_pkg::*;

  logic [DIG_W-1:0] dig_q;
  logic [DIG_W-1:0] dig_d;
  logic [DIG_W-1:0] adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (dig_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = dig_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = dig_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    dig_d = dig_q;
    if (ctl_i.load) begin
      dig_d = {{(DIG_W-VALUE_BITS){1'b0}}, load_val_i};
    end else if (ctl_i.dabble) begin
      dig_d = {adj[DIG_W-2:0], ctl_i.bit_in};
    end else if (ctl_i.shift) begin
      dig_d = {dig_q[DIG_W-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
  end

  assign top_o = dig_q[DIG_W-1 -: 4];

endmodule

FILE: design/integer_to_ascii_formatter_unit.sv
// top level: operand load, conversion sequencer and character output
`timescale 1ns / 1ps

// Formats one integer as ASCII text, most significant character first.
// Input: item_i is taken at a clock edge where start is high and busy
// is low. busy stays high until the last character is produced. An item
// with the unused format code or a room of zero is taken and dropped with
// no output and busy stays low.
// Output: each character appears on result_o for one cycle with strobe_o
// high; result_o.last marks the final one. Characters of one item come in
// consecutive cycles. The receiver cannot stall; there is no back pressure.
// Sequence: decimal formats run the double-dabble loop over all VALUE_BITS
// bits (one operand bit a cycle), hex loads the digit register at once. A
// leading-zero skip then drops the zero digits at the top, and output
// emits the characters. The next item can be accepted in the cycle in
// which the last character appears on the outputs.
// Reset clears the sequencer and the output strobe; no clearing pass.

module integer_to_ascii_formatter_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  ifmt_pkg::ifmt_in_t  item_i,
  output logic                strobe_o,
  output ifmt_pkg::ifmt_out_t result_o
);
  import ifmt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_e;

  localparam int NARROW_SH = VALUE_BITS - 32;

  state_e                state_q;
  logic [VALUE_BITS-1:0] mag_q;
  logic [VALUE_BITS-1:0] mag_d;
  logic [CNT_W-1:0]      cnt_q;
  logic [SKIP_W-1:0]     skip_q;
  logic [LEFT_W-1:0]     left_q;
  logic [ROOM_W-1:0]     room_q;
  logic                  sign_q;
  logic                  neg_d;
  logic                  strobe_q;
  ifmt_out_t             result_q;

  logic [VALUE_BITS-1:0] wmask;
  logic [VALUE_BITS-1:0] raw;
  logic                  msb;
  logic                  accept;
  logic                  run;
  logic [3:0]            top_nib;
  logic                  last_char;
  ifmt_bcd_ctl_t         bcd_ctl;

  assign accept = start && !busy;
  assign run    = accept && (item_i.op != OP_NONE) && (item_i.room != '0);

  // operand width, sign and magnitude
  always_comb begin
    wmask = item_i.wide ? {VALUE_BITS{1'b1}} : ({VALUE_BITS{1'b1}} >> NARROW_SH);
    raw   = item_i.value[VALUE_BITS-1:0] & wmask;
    msb   = item_i.wide ? raw[VALUE_BITS-1] : raw[31];
    neg_d = (item_i.op == OP_SDEC) && msb;
    mag_d = neg_d ? (((~raw) + 1'b1) & wmask) : raw;
  end

  always_comb begin
    bcd_ctl        = '0;
    bcd_ctl.bit_in = mag_q[VALUE_BITS-1];
    if (run) begin
      bcd_ctl.load = 1'b1;
    end else begin
      unique case (state_q)
        ST_CONV: bcd_ctl.dabble = 1'b1;
        ST_SKIP: bcd_ctl.shift  = (top_nib == 4'd0) && (skip_q != '0);
        ST_EMIT: bcd_ctl.shift  = !sign_q;
        default: bcd_ctl.shift  = 1'b0;
      endcase
    end
  end

  ifmt_bcd u_bcd (
    .clk_i      (clk_i),
    .ctl_i      (bcd_ctl),
    .load_val_i ((item_i.op == OP_HEX) ? mag_d : {VALUE_BITS{1'b0}}),
    .top_o      (top_nib)
  );

  assign last_char = (room_q == 8'd1) || (!sign_q && (left_q == LEFT_W'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
      sign_q   <= 1'b0;
      cnt_q    <= '0;
      skip_q   <= '0;
      left_q   <= '0;
      room_q   <= '0;
      mag_q    <= '0;
      result_q <= '0;
    end else begin
      strobe_q <= (state_q == ST_EMIT);
      unique case (state_q)
        ST_IDLE: begin
          if (run) begin
            mag_q  <= mag_d;
            sign_q <= neg_d;
            room_q <= item_i.room;
            cnt_q  <= CNT_W'(VALUE_BITS - 1);
            skip_q <= SKIP_W'(NDIG - 1);
            state_q <= (item_i.op == OP_HEX) ? ST_SKIP : ST_CONV;
          end
        end
        ST_CONV: begin
          mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if ((top_nib == 4'd0) && (skip_q != '0)) begin
            skip_q <= skip_q - 1'b1;
          end else begin
            left_q  <= LEFT_W'(skip_q) + 1'b1;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          result_q.last  <= last_char;
          room_q         <= room_q - 1'b1;
          if (sign_q) begin
            result_q.char_code <= CH_MINUS;
            sign_q             <= 1'b0;
          end else begin
            result_q.char_code <= nib_to_char(top_nib);
            left_q             <= left_q - 1'b1;
          end
          if (last_char) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy     = (state_q != ST_IDLE);
  assign strobe_o = strobe_q;
  assign result_o = result_q;

  // a final character is never followed directly by another one
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && result_o.last |=> !strobe_o)
    else $error("character strobed right after a final character");

  // characters of one item come back to back
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !result_o.last |=> strobe_o)
    else $error("gap inside a character run");

  // a valid item makes the block busy
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run |=> busy)
    else $error("valid item accepted but block not busy");

  // output never runs past the allowed room
  a_room_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> room_q != '0)
    else $error("emitting with no room left");

endmodule

FILE: sim/ifmt_char_checker.sv
// checker for the integer to ascii formatter: predicts each word's text and compares
`timescale 1ns / 1ps

module ifmt_char_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  ifmt_pkg::ifmt_in_t  item_i,
  input  logic                strobe_i,
  input  ifmt_pkg::ifmt_out_t result_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  chars_o
);
  import ifmt_pkg::*;

  localparam int MAX_CHARS = 20;

  ifmt_out_t expected_chars[$];
  int        mismatches = 0;
  int        chars_seen = 0;

  // builds the text of one word and queues the characters that fit in room
  task automatic predict_text(input ifmt_in_t w);
    logic [VAL_W-1:0]  mag;
    logic [VAL_W-1:0]  mask;
    logic [3:0]        nib;
    logic [CHAR_W-1:0] digits[MAX_CHARS];
    logic [CHAR_W-1:0] text[MAX_CHARS];
    int                bits;
    int                nd;
    int                nt;
    int                emit;
    bit                neg;
    ifmt_out_t         exp_char;
    if (w.op == OP_NONE || w.room == '0) return;
    bits = w.wide ? VALUE_BITS : 32;
    mask = {VAL_W{1'b1}} >> (VAL_W - bits);
    mag  = w.value & mask;
    neg  = (w.op == OP_SDEC) && mag[bits-1];
    // magnitude taken unsigned so the most negative value survives
    if (neg) mag = (~mag + 1'b1) & mask;
    nd = 0;
    nt = 0;
    if (mag == '0) begin
      digits[nd++] = CH_ZERO;
    end else if (w.op == OP_HEX) begin
      while (mag != '0 && nd < MAX_CHARS) begin
        nib = mag[3:0];
        digits[nd++] = (nib < 4'd10) ? CH_ZERO + {4'd0, nib} : CH_A + {4'd0, nib} - 8'd10;
        mag = mag >> 4;
      end
    end else begin
      while (mag != '0 && nd < MAX_CHARS) begin
        digits[nd++] = CH_ZERO + CHAR_W'(mag % 10);
        mag = mag / 10;
      end
    end
    if (neg) text[nt++] = CH_MINUS;
    for (int k = nd; k > 0 && nt < MAX_CHARS; k--) text[nt++] = digits[k-1];
    emit = (nt < int'(w.room)) ? nt : int'(w.room);
    for (int k = 0; k < emit; k++) begin
      exp_char.char_code = text[k];
      exp_char.last      = (k + 1 == emit);
      expected_chars.push_back(exp_char);
    end
  endtask

  task automatic log_mismatch(input string what, input ifmt_out_t want, input ifmt_out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch (%s): expected char 0x%02h last %0b, got char 0x%02h last %0b",
               $realtime, what, want.char_code, want.last, got.char_code, got.last);
    end
  endtask

  always @(posedge clk_i) begin
    ifmt_out_t want;
    if (rst_ni) begin
      if (strobe_i) begin
        chars_seen++;
        if (expected_chars.size() == 0) begin
          log_mismatch("no character expected", '0, result_i);
        end else begin
          want = expected_chars.pop_front();
          if (result_i.char_code !== want.char_code) begin
            log_mismatch("char_code", want, result_i);
          end else if (result_i.last !== want.last) begin
            log_mismatch("last", want, result_i);
          end
        end
      end
      // old characters leave the queue before the new word's are added
      if (start_i && !busy_i) predict_text(item_i);
    end
    errors_o  <= mismatches;
    pending_o <= expected_chars.size();
    chars_o   <= chars_seen;
  end

endmodule

FILE: sim/integer_to_ascii_formatter_unit_tb.sv
// testbench top for the integer to ascii formatter: stimulus, pacing and verdict
`timescale 1ns / 1ps

module integer_to_ascii_formatter_unit_tb;
  import ifmt_pkg::*;

  localparam int N_RANDOM    = 290;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 120;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  ifmt_in_t  item;
  logic      strobe;
  ifmt_out_t result;

  int fail_count;
  int pending_chars;
  int chars_checked;
  int words_sent = 0;
  int burst_left = 0;
  int directed_words;

  logic [OP_W-1:0] fmt_ops[3] = '{OP_SDEC, OP_UDEC, OP_HEX};

  integer_to_ascii_formatter_unit dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .start   (start),
    .busy    (busy),
    .item_i  (item),
    .strobe_o(strobe),
    .result_o(result)
  );

  ifmt_char_checker u_checker (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .start_i  (start),
    .busy_i   (busy),
    .item_i   (item),
    .strobe_i (strobe),
    .result_i (result),
    .errors_o (fail_count),
    .pending_o(pending_chars),
    .chars_o  (chars_checked)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic ifmt_in_t mk_word(input logic [VAL_W-1:0] value,
                                       input logic [OP_W-1:0] op,
                                       input logic wide,
                                       input logic [ROOM_W-1:0] room);
    ifmt_in_t w;
    w.value = value;
    w.op    = op;
    w.wide  = wide;
    w.room  = room;
    return w;
  endfunction

  // start stays high until the word is taken
  task automatic send_word(input ifmt_in_t w);
    start <= 1'b1;
    item  <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  // bursts of back-to-back words with random gaps between them
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(10, 30) : $urandom_range(0, 6);
    end
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] p;
    case ($urandom_range(0, 7))
      0: v = VAL_W'($urandom_range(0, 99));
      1: v = {$urandom, $urandom} & (({VAL_W{1'b1}}) >> $urandom_range(0, 63));
      2: begin
        // near a power of ten, where digit counts change
        p = 1;
        repeat ($urandom_range(0, 19)) p = p * 10;
        v = p + VAL_W'($urandom_range(0, 2)) - 1;
      end
      3: v = {VAL_W{1'b0}} | (VAL_W'(1) << $urandom_range(0, 63));
      4: v = ~(VAL_W'($urandom_range(0, 99)));
      5: v = {$urandom, 32'(-$urandom_range(1, 1000))};
      6: v = $urandom_range(0, 1) ? {1'b1, {(VAL_W-1){1'b0}}} : {32'h0, 32'h8000_0000};
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic ifmt_in_t pick_word();
    logic [OP_W-1:0]   op;
    logic [ROOM_W-1:0] room;
    op = ($urandom_range(0, 15) == 0) ? OP_NONE : fmt_ops[$urandom_range(0, 2)];
    case ($urandom_range(0, 9))
      0:       room = '0;
      1, 2, 3: room = ROOM_W'($urandom_range(1, 20));
      default: room = ROOM_W'($urandom_range(21, 255));
    endcase
    return mk_word(pick_value(), op, 1'($urandom_range(0, 1)), room);
  endfunction

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin
    ifmt_in_t directed[$];
    rst_n = 1'b0;
    start = 1'b0;
    item  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(mk_word(64'h0, OP_SDEC, 1'b0, 8'd20));
    directed.push_back(mk_word(64'hffff_ffff_8000_0000, OP_SDEC, 1'b0, 8'd255));
    directed.push_back(mk_word(64'h0000_0000_ffff_ffff, OP_SDEC, 1'b0, 8'd20));
    directed.push_back(mk_word(64'h0000_0000_7fff_ffff, OP_SDEC, 1'b0, 8'd20));
    directed.push_back(mk_word(64'h8000_0000_0000_0000, OP_SDEC, 1'b1, 8'd20));
    directed.push_back(mk_word(64'hffff_ffff_ffff_ffff, OP_SDEC, 1'b1, 8'd255));
    directed.push_back(mk_word(64'h7fff_ffff_ffff_ffff, OP_SDEC, 1'b1, 8'd30));
    directed.push_back(mk_word(64'hffff_ffff_ffff_ffff, OP_UDEC, 1'b1, 8'd20));
    directed.push_back(mk_word(64'hffff_ffff_ffff_ffff, OP_UDEC, 1'b1, 8'd19));
    directed.push_back(mk_word(64'hdead_beef_ffff_ffff, OP_UDEC, 1'b0, 8'd255));
    directed.push_back(mk_word(64'h0, OP_UDEC, 1'b1, 8'd1));
    directed.push_back(mk_word(64'hffff_ffff_ffff_ffff, OP_HEX, 1'b1, 8'd255));
    directed.push_back(mk_word(64'h0123_4567_89ab_cdef, OP_HEX, 1'b1, 8'd20));
    directed.push_back(mk_word(64'h1234_5678_0000_00ff, OP_HEX, 1'b0, 8'd20));
    directed.push_back(mk_word(64'hfedc_ba98_7654_3210, OP_HEX, 1'b1, 8'd5));
    directed.push_back(mk_word(64'h0, OP_HEX, 1'b0, 8'd255));
    // no room, unused selector, and truncation right at the sign
    directed.push_back(mk_word(64'hffff_ffff_ffff_ffff, OP_SDEC, 1'b1, 8'd0));
    directed.push_back(mk_word(64'h0000_0000_0000_1234, OP_NONE, 1'b1, 8'd20));
    directed.push_back(mk_word(64'h0000_0000_ffff_fff6, OP_SDEC, 1'b0, 8'd1));
    directed.push_back(mk_word(64'h8000_0000_0000_0000, OP_SDEC, 1'b1, 8'd3));
    directed.push_back(mk_word(64'h0000_0000_0000_0009, OP_UDEC, 1'b1, 8'd255));
    directed_words = directed.size();
    foreach (directed[i]) begin
      send_word(directed[i]);
      pace();
    end

    repeat (N_RANDOM) begin
      send_word(pick_word());
      pace();
    end
    start <= 1'b0;

    // let the checker see the last acceptance before reading its backlog
    @(posedge clk);
    while (pending_chars != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d words (%0d directed) in all three formats, both widths",
             words_sent, directed_words);
    $display("and %0d characters compared, with truncation, no room and the unused code",
             chars_checked);
    if (fail_count == 0 && pending_chars == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/ifmt_pkg.sv
design/ifmt_bcd.sv
design/integer_to_ascii_formatter_unit.sv
sim/ifmt_char_checker.sv
sim/integer_to_ascii_formatter_unit_tb.sv
